[sv/rotated_rect_fill_engine_macros.svh]
// ----------------------------------------------------------------------------
// rotated rect fill engine assertion macros
// shared property forms for the fill engine checks
// ----------------------------------------------------------------------------
`ifndef ROTATED_RECT_FILL_ENGINE_MACROS_SVH
`define ROTATED_RECT_FILL_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, idle in reset
`define RRFE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrfe check failed");

// next-cycle implication, sampled on clk, idle in reset
`define RRFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrfe check failed");

`endif

[sv/rrfe_pkg.sv]
// ----------------------------------------------------------------------------
// rrfe_pkg
// shared codes, control structs and colour packing for the fill engine
// ----------------------------------------------------------------------------
`default_nettype none

package rrfe_pkg;

    // opcodes
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PHYS_W   = 3'd0;
    localparam logic [2:0] REG_PHYS_H   = 3'd1;
    localparam logic [2:0] REG_VIRT_W   = 3'd2;
    localparam logic [2:0] REG_WIDE     = 3'd3;
    localparam logic [2:0] REG_ROTATION = 3'd4;
    localparam logic [2:0] REG_BRIGHT   = 3'd5;
    localparam logic [2:0] REG_LAYOUT   = 3'd6;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [8:0] BRIGHT_MIN = 9'd13;
    localparam logic [8:0] BRIGHT_MAX = 9'd256;

    typedef struct packed {
        logic load;      // latch a fill or clear beat
        logic rd_issue;  // read the canvas word
        logic out_load;  // load the result register
        logic pix_step;  // issue one pixel into the pipe
        logic clr_step;  // zero one canvas word after reset
    } cmd_t;

    typedef struct packed {
        logic rect_empty;
        logic pix_last;
        logic pipe_busy;
        logic clr_last;
    } status_t;

    // scale one channel by brightness with rounding, then place it
    function automatic logic [31:0] chan(input logic [7:0] c, input logic [8:0] bq,
                                         input logic [8:0] f);
        logic [16:0] p;
        logic [7:0]  s;
        logic [3:0]  len;
        logic [3:0]  sh;
        logic [39:0] w;
        p   = 17'(c) * 17'(bq) + 17'd128;
        s   = p[15:8];
        len = (f[8:5] > 4'd8) ? 4'd8 : f[8:5];
        sh  = 4'd8 - len;
        w   = 40'(s >> sh) << f[4:0];
        return w[31:0];
    endfunction

    function automatic logic [31:0] pack(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [8:0] bq,
                                         input logic [26:0] lay);
        return chan(r, bq, lay[8:0]) | chan(g, bq, lay[17:9]) | chan(b, bq, lay[26:18]);
    endfunction

endpackage

`default_nettype wire

[sv/rotated_rect_fill_engine.sv]
// ----------------------------------------------------------------------------
// rotated_rect_fill_engine
// rectangle fill blitter over a byte canvas with quarter-turn rotation
// ----------------------------------------------------------------------------
// After reset the engine zeroes its canvas one 32-bit word per cycle;
// in_stall stays high for that sweep, configuration writes are taken
// throughout. A fill beat then issues each clipped pixel into the
// three-stage address pipe (rotate, row multiply, word write) and drains
// it; a clear does the same over the whole phys_width by phys_height
// area; a read gives one result beat. The canvas has a single write port
// shared by the sweep and the pipe, so one pixel a cycle is the fill
// throughput. A new beat is taken only once the previous one is done and
// no read result is waiting at the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotated_rect_fill_engine_macros.svh"

module rotated_rect_fill_engine #(
    parameter int CANVAS_BYTES = 1048576,
    parameter int MAX_WIDTH    = 512,
    parameter int MAX_HEIGHT   = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration writes
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [26:0]        cfg_data,
    // input beats
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic signed [15:0] rect_w,
    input  wire logic signed [15:0] rect_h,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic [17:0]        word_address,
    // result beats
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             read_data
);

    rrfe_pkg::cmd_t    cmd;
    rrfe_pkg::status_t status;

    // sequencer
    rrfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // registers, pixel pipe and canvas
    rrfe_datapath #(
        .CANVAS_BYTES (CANVAS_BYTES),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .word_address (word_address),
        .cmd          (cmd),
        .status       (status),
        .read_data    (read_data)
    );

    // an accepted read beat shows its result once the sequencer has passed through its read state
    `RRFE_ASSERT_IMPL(a_read_result, in_valid && !in_stall && opcode == rrfe_pkg::OP_READ, ##2 out_valid)
    // no pixel is in flight while a new beat can be taken
    `RRFE_ASSERT_IMPL(a_pipe_blocks_input, status.pipe_busy, in_stall)
    // a pending result keeps the input side shut
    `RRFE_ASSERT_IMPL(a_result_blocks_input, out_valid, in_stall)
    // a clear or fill beat never yields a result
    `RRFE_ASSERT_NEXT(a_fill_no_result, in_valid && !in_stall && opcode != rrfe_pkg::OP_READ && !out_valid, !out_valid)

endmodule

`default_nettype wire

[sv/rrfe_ctrl.sv]
// ----------------------------------------------------------------------------
// rrfe_ctrl
// sequencer: reset sweep, pixel issue, pipe drain and read result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module rrfe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        opcode,
    input  wire logic              out_stall,
    input  wire rrfe_pkg::status_t status,
    output logic                   in_stall,
    output logic                   out_valid,
    output rrfe_pkg::cmd_t         cmd
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        rrfe_pkg::OP_FILL, rrfe_pkg::OP_CLEAR:
                        begin
                            cmd.load = 1'b1;
                            if (!status.rect_empty)
                                state_next = S_FILL;
                        end
                        rrfe_pkg::OP_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL:
            begin
                cmd.pix_step = 1'b1;
                if (status.pix_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[sv/rrfe_datapath.sv]
// ----------------------------------------------------------------------------
// rrfe_datapath
// registers, clipping, pixel counters, address pipe and canvas memory
// ----------------------------------------------------------------------------
`default_nettype none

module rrfe_datapath #(
    parameter int CANVAS_BYTES = 1048576,
    parameter int MAX_WIDTH    = 512,
    parameter int MAX_HEIGHT   = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [26:0]        cfg_data,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic signed [15:0] rect_w,
    input  wire logic signed [15:0] rect_h,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic [17:0]        word_address,
    input  wire rrfe_pkg::cmd_t     cmd,
    output rrfe_pkg::status_t       status,
    output logic [31:0]             read_data
);

    localparam int WORDS = CANVAS_BYTES / 4;
    localparam int AW    = $clog2(WORDS);

    // configuration
    logic [9:0]  pw_reg, pw_next, ph_reg, ph_next, vw_reg, vw_next;
    logic        wide_reg, wide_next;
    logic [1:0]  rot_reg, rot_next;
    logic [8:0]  bq_reg, bq_next;
    logic [26:0] lay_reg, lay_next;
    logic [9:0]  sz;

    always_comb
    begin
        pw_next   = pw_reg;
        ph_next   = ph_reg;
        vw_next   = vw_reg;
        wide_next = wide_reg;
        rot_next  = rot_reg;
        bq_next   = bq_reg;
        lay_next  = lay_reg;
        sz        = cfg_data[9:0];
        if (cfg_we)
        begin
            case (cfg_index)
                rrfe_pkg::REG_PHYS_W:
                    pw_next = (32'(sz) > MAX_WIDTH) ? 10'(MAX_WIDTH) : sz;
                rrfe_pkg::REG_PHYS_H:
                    ph_next = (32'(sz) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : sz;
                rrfe_pkg::REG_VIRT_W:
                    vw_next = (32'(sz) > MAX_WIDTH) ? 10'(MAX_WIDTH) : sz;
                rrfe_pkg::REG_WIDE:     wide_next = cfg_data[0];
                rrfe_pkg::REG_ROTATION: rot_next  = cfg_data[1:0];
                rrfe_pkg::REG_BRIGHT:
                begin
                    if (cfg_data[8:0] < rrfe_pkg::BRIGHT_MIN)
                        bq_next = rrfe_pkg::BRIGHT_MIN;
                    else if (cfg_data[8:0] > rrfe_pkg::BRIGHT_MAX)
                        bq_next = rrfe_pkg::BRIGHT_MAX;
                    else
                        bq_next = cfg_data[8:0];
                end
                rrfe_pkg::REG_LAYOUT:   lay_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg   <= 10'(320 > MAX_WIDTH ? MAX_WIDTH : 320);
            ph_reg   <= 10'(240 > MAX_HEIGHT ? MAX_HEIGHT : 240);
            vw_reg   <= 10'(320 > MAX_WIDTH ? MAX_WIDTH : 320);
            wide_reg <= 1'b1;
            rot_reg  <= rrfe_pkg::ROT_0;
            bq_reg   <= rrfe_pkg::BRIGHT_MAX;
            lay_reg  <= 27'd67244304;
        end
        else
        begin
            pw_reg   <= pw_next;
            ph_reg   <= ph_next;
            vw_reg   <= vw_next;
            wide_reg <= wide_next;
            rot_reg  <= rot_next;
            bq_reg   <= bq_next;
            lay_reg  <= lay_next;
        end
    end

    // clipping of the incoming rectangle
    logic [9:0]         lw, lh;
    logic signed [16:0] x0c, y0c, x1c, y1c, xe, ye;
    logic               is_clear, fill_empty;

    always_comb
    begin
        lw         = rot_reg[0] ? ph_reg : pw_reg;
        lh         = rot_reg[0] ? pw_reg : ph_reg;
        xe         = {rect_x[15], rect_x} + {rect_w[15], rect_w};
        ye         = {rect_y[15], rect_y} + {rect_h[15], rect_h};
        x0c        = rect_x[15] ? 17'sd0 : {1'b0, rect_x};
        y0c        = rect_y[15] ? 17'sd0 : {1'b0, rect_y};
        x1c        = (xe < $signed({7'd0, lw})) ? xe : $signed({7'd0, lw});
        y1c        = (ye < $signed({7'd0, lh})) ? ye : $signed({7'd0, lh});
        fill_empty = !(x0c < x1c) || !(y0c < y1c);
        is_clear   = (opcode == rrfe_pkg::OP_CLEAR);
    end

    // pixel counters
    logic [9:0]  x0_reg, x1_reg, y1_reg, lx_reg, ly_reg;
    logic [1:0]  rot_eff_reg;
    logic [31:0] color_reg;
    logic        x_end;

    assign x_end = (lx_reg == x1_reg - 10'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg      <= is_clear ? 10'd0 : x0c[9:0];
            x1_reg      <= is_clear ? pw_reg : x1c[9:0];
            y1_reg      <= is_clear ? ph_reg : y1c[9:0];
            lx_reg      <= is_clear ? 10'd0 : x0c[9:0];
            ly_reg      <= is_clear ? 10'd0 : y0c[9:0];
            rot_eff_reg <= is_clear ? rrfe_pkg::ROT_0 : rot_reg;
            color_reg   <= rrfe_pkg::pack(red, green, blue, bq_reg, lay_reg);
        end
        else if (cmd.pix_step)
        begin
            if (x_end)
            begin
                lx_reg <= x0_reg;
                ly_reg <= ly_reg + 10'd1;
            end
            else
                lx_reg <= lx_reg + 10'd1;
        end
    end

    // stage 1: rotation, stage 2: row multiply
    logic       s1_v_reg, s2_v_reg;
    logic [9:0] s1_px_reg, s1_py_reg, s2_px_reg;
    logic [19:0] s2_prod_reg;
    logic [9:0] px_m, py_m;

    always_comb
    begin
        case (rot_eff_reg)
            rrfe_pkg::ROT_90:
            begin
                px_m = pw_reg - 10'd1 - ly_reg;
                py_m = lx_reg;
            end
            rrfe_pkg::ROT_180:
            begin
                px_m = pw_reg - 10'd1 - lx_reg;
                py_m = ph_reg - 10'd1 - ly_reg;
            end
            rrfe_pkg::ROT_270:
            begin
                px_m = ly_reg;
                py_m = ph_reg - 10'd1 - lx_reg;
            end
            default:
            begin
                px_m = lx_reg;
                py_m = ly_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.pix_step;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg   <= px_m;
        s1_py_reg   <= py_m;
        s2_px_reg   <= s1_px_reg;
        s2_prod_reg <= s1_py_reg * vw_reg;
    end

    // stage 3: byte address and word write
    logic [20:0] pix_idx;
    logic [31:0] addr;
    logic        wr_ok;
    logic [AW-1:0] wr_idx;
    logic [3:0]  be;
    logic [31:0] wr_data;

    always_comb
    begin
        pix_idx = 21'(s2_prod_reg) + 21'(s2_px_reg);
        addr    = wide_reg ? {9'd0, pix_idx, 2'b00} : {10'd0, pix_idx, 1'b0};
        wr_ok   = s2_v_reg && (addr < 32'(CANVAS_BYTES));
        wr_idx  = addr[AW+1:2];
        if (wide_reg)
        begin
            be      = 4'hF;
            wr_data = color_reg;
        end
        else
        begin
            be      = addr[1] ? 4'b1100 : 4'b0011;
            wr_data = {color_reg[15:0], color_reg[15:0]};
        end
    end

    // reset sweep
    logic [AW-1:0] sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.clr_step)
            sweep_reg <= sweep_reg + 1'b1;
    end

    // canvas memory, one word per entry
    logic [31:0]   mem [WORDS];
    logic [31:0]   rd_q_reg;
    logic          rd_ok_reg;
    logic [31:0]   rd_addr;
    logic [31:0]   read_data_reg;

    assign rd_addr = 32'(word_address);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[sweep_reg] <= '0;
        else if (wr_ok)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (be[i])
                    mem[wr_idx][8*i +: 8] <= wr_data[8*i +: 8];
            end
        end
        if (cmd.rd_issue)
        begin
            rd_q_reg  <= mem[rd_addr[AW-1:0]];
            rd_ok_reg <= rd_addr < 32'(WORDS);
        end
        if (cmd.out_load)
            read_data_reg <= rd_ok_reg ? rd_q_reg : 32'd0;
    end

    assign read_data = read_data_reg;

    always_comb
    begin
        status.rect_empty = is_clear ? (pw_reg == 10'd0 || ph_reg == 10'd0) : fill_empty;
        status.pix_last   = x_end && (ly_reg == y1_reg - 10'd1);
        status.pipe_busy  = s1_v_reg || s2_v_reg;
        status.clr_last   = (sweep_reg == AW'(WORDS - 1));
    end

endmodule

`default_nettype wire
